// ----- sv/rpa_pkg.sv -----
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes for the reference counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_SEED  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;
  localparam logic [1:0] STATUS_ZERO_CNT = 2'd3;

  localparam logic REG_LOW_LIMIT  = 1'b0;
  localparam logic REG_HIGH_LIMIT = 1'b1;

  localparam logic [ADDR_W-1:0] LOW_LIMIT_RESET  = 32'h0000_0000;
  localparam logic [ADDR_W-1:0] HIGH_LIMIT_RESET = 32'h0800_0000;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } alloc_state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] page_addr;
  } page_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_addr;
    logic              returned;
  } page_rsp_t;

endpackage

// ----- sv/refcounted_page_allocator.sv -----
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Page allocator with a last-in first-out free stack and a reference count
// per page, both held in synchronous memories.
// ----------------------------------------------------------------------------
//
// Channel   Handshake              Word
// request   start / busy           req: action, page_addr
// result    done (one-cycle pulse) rsp: status, result_addr, returned
// config    APB write/read         low_limit at 0x0, high_limit at 0x4
//
// For every word, the accept edge reads both memories, and the following
// edge writes them back and registers the result, which shows on rsp, with
// done high for one cycle, while the next word can already be accepted.
// After reset the count memory is cleared one entry a cycle, all NUM_PAGES
// entries with busy high; configuration writes are taken throughout.
// The receiver cannot stall, so no result is ever held back.
//
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rpa_pkg::page_req_t req,
  output logic               done,
  output rpa_pkg::page_rsp_t rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import rpa_pkg::*;

  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW = $clog2(NUM_PAGES + 1);

  alloc_state_t state, state_next;

  logic [ADDR_W-1:0] low_limit;
  logic [ADDR_W-1:0] high_limit;

  logic [CW-1:0] stack_count, stack_count_next;
  logic [PW-1:0] clr_idx;
  logic [1:0]    act;
  logic [PW-1:0] page;
  logic          addr_valid;

  logic [PW-1:0]         free_stack [NUM_PAGES];
  logic [COUNT_BITS-1:0] ref_counts [NUM_PAGES];
  logic [PW-1:0]         stack_rd;
  logic [COUNT_BITS-1:0] count_rd;

  logic                  accept;
  logic                  cfg_write;
  logic                  req_addr_ok;
  logic [CW-1:0]         count_dec;
  logic [COUNT_BITS-1:0] ref_dec;
  logic                  stack_we;
  logic [PW-1:0]         stack_wa;
  logic [PW-1:0]         stack_wd;
  logic                  count_we;
  logic [PW-1:0]         count_wa;
  logic [COUNT_BITS-1:0] count_wd;
  page_rsp_t             rsp_next;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign count_dec = stack_count - {{(CW-1){1'b0}}, 1'b1};
  assign ref_dec   = count_rd - {{(COUNT_BITS-1){1'b0}}, 1'b1};

  assign req_addr_ok = (req.page_addr[PAGE_SHIFT-1:0] == '0) &&
                       (req.page_addr >= low_limit) &&
                       (req.page_addr < high_limit) &&
                       ((req.page_addr >> PAGE_SHIFT) < 32'(NUM_PAGES));

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= LOW_LIMIT_RESET;
      high_limit <= HIGH_LIMIT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_HIGH_LIMIT) begin
        high_limit <= pwdata;
      end else begin
        low_limit <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_LOW_LIMIT) begin
      prdata = low_limit;
    end else begin
      prdata = high_limit;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == PW'(NUM_PAGES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy   = (state != ST_IDLE);
    accept = start && (state == ST_IDLE);
  end

  always_comb begin
    stack_count_next = stack_count;
    stack_we         = 1'b0;
    stack_wa         = stack_count[PW-1:0];
    stack_wd         = page;
    count_we         = 1'b0;
    count_wa         = page;
    count_wd         = ref_dec;
    rsp_next         = '0;
    if (state == ST_CLEAR) begin
      count_we = 1'b1;
      count_wa = clr_idx;
      count_wd = '0;
    end else if (state == ST_EXEC) begin
      unique case (act)
        ACT_ALLOC: begin
          if (stack_count == '0) begin
            rsp_next.status = STATUS_NO_FREE;
          end else begin
            stack_count_next     = count_dec;
            count_we             = 1'b1;
            count_wa             = stack_rd;
            count_wd             = {{(COUNT_BITS-1){1'b0}}, 1'b1};
            rsp_next.result_addr = ADDR_W'(stack_rd) << PAGE_SHIFT;
          end
        end
        ACT_FREE: begin
          if (!addr_valid) begin
            rsp_next.status = STATUS_BAD_ADDR;
          end else if (count_rd == '0) begin
            rsp_next.status = STATUS_ZERO_CNT;
          end else begin
            count_we = 1'b1;
            if ((ref_dec == '0) && (stack_count < CW'(NUM_PAGES))) begin
              stack_we          = 1'b1;
              stack_count_next  = stack_count + {{(CW-1){1'b0}}, 1'b1};
              rsp_next.returned = 1'b1;
            end
          end
        end
        ACT_SEED: begin
          if (!addr_valid) begin
            rsp_next.status = STATUS_BAD_ADDR;
          end else if (stack_count >= CW'(NUM_PAGES)) begin
            rsp_next.status = STATUS_NO_FREE;
          end else begin
            stack_we         = 1'b1;
            stack_count_next = stack_count + {{(CW-1){1'b0}}, 1'b1};
          end
        end
        default: begin
          rsp_next.status = STATUS_BAD_ADDR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      stack_count <= '0;
      clr_idx     <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      stack_count <= stack_count_next;
      done        <= (state == ST_EXEC);
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + {{(PW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act        <= req.action;
      page       <= req.page_addr[PAGE_SHIFT +: PW];
      addr_valid <= req_addr_ok;
    end
    if (state == ST_EXEC) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stack_rd <= free_stack[count_dec[PW-1:0]];
    end
    if (stack_we) begin
      free_stack[stack_wa] <= stack_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count_rd <= ref_counts[req.page_addr[PAGE_SHIFT +: PW]];
    end
    if (count_we) begin
      ref_counts[count_wa] <= count_wd;
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("Result strobe without a preceding execute cycle.");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC) && busy)
    else $error("Accepted word did not enter the execute cycle.");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CW'(NUM_PAGES))
    else $error("Free stack count exceeds the number of pages.");

  a_stack_step: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EXEC) |=> $stable(stack_count))
    else $error("Free stack count moved outside an execute cycle.");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status != STATUS_OK) |-> (rsp.result_addr == '0) && !rsp.returned)
    else $error("Failed request carries an address or a returned flag.");

endmodule
